// ===== rtl/styp_pkg.sv =====
// Package: beat types, glyph batch types, byte constants, classification functions and the per-byte glyph decision.
`timescale 1ns / 1ps
`default_nettype none
package styp_pkg;

   localparam logic [7:0] BYTE_LEAD  = 8'hE2;
   localparam logic [7:0] BYTE_MID   = 8'h80;
   localparam logic [7:0] TAIL_EM    = 8'h94;
   localparam logic [7:0] TAIL_EN    = 8'h93;
   localparam logic [7:0] TAIL_ELL   = 8'hA6;
   localparam logic [7:0] TAIL_LSQ   = 8'h98;
   localparam logic [7:0] TAIL_RSQ   = 8'h99;
   localparam logic [7:0] TAIL_LDQ   = 8'h9C;
   localparam logic [7:0] TAIL_RDQ   = 8'h9D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_DASH  = 8'h2D;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_APOS  = 8'h27;
   localparam logic [7:0] CHAR_DQUOT = 8'h22;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        glyph_start;
      logic [15:0] source_index;
      logic        run_end;
      logic        string_end;
   } rsp_type;

   // one decided glyph: either one plain byte or a three-byte sequence
   typedef struct packed {
      logic        len3;
      logic [7:0]  b0;
      logic [7:0]  b2;
      logic [15:0] src;
   } glyph_type;

   typedef struct packed {
      logic [2:0]            mask;
      logic                  last;
      glyph_type [2:0]       glyphs;
   } batch_type;

   typedef struct packed {
      logic       len3;
      logic [7:0] b0;
      logic [7:0] b2;
      logic [1:0] used;
      logic       sq;
   } step_type;

   function automatic logic is_alnum(input logic [7:0] b);
      return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
             (b >= 8'h61 && b <= 8'h7A);
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return b == CHAR_SPACE || (b >= 8'h09 && b <= 8'h0D);
   endfunction

   function automatic logic is_punct(input logic [7:0] b);
      return (b >= 8'h21 && b <= 8'h2F) || (b >= 8'h3A && b <= 8'h40) ||
             (b >= 8'h5B && b <= 8'h60) || (b >= 8'h7B && b <= 8'h7E);
   endfunction

   // decision for one byte given its lookahead, previous byte and quote phase
   function automatic step_type decide_step(input logic [7:0] c, input logic [7:0] n1,
                                            input logic h1, input logic [7:0] n2,
                                            input logic h2, input logic [7:0] prev,
                                            input logic sq);
      step_type   s;
      logic       d1;
      logic       d2;
      logic [7:0] nx;
      d1     = h1 && n1 == CHAR_DASH;
      d2     = h2 && n2 == CHAR_DASH;
      nx     = h1 ? n1 : CHAR_SPACE;
      s.len3 = 1'b1;
      s.b0   = BYTE_LEAD;
      s.b2   = TAIL_EM;
      s.used = 2'd1;
      s.sq   = sq;
      if (c == CHAR_DASH && d1 && d2) begin
         s.used = 2'd3;
      end else if (c == CHAR_DASH && d1) begin
         s.b2   = TAIL_EN;
         s.used = 2'd2;
      end else if (c == CHAR_DOT && h1 && n1 == CHAR_DOT && h2 && n2 == CHAR_DOT) begin
         s.b2   = TAIL_ELL;
         s.used = 2'd3;
      end else if (c == CHAR_APOS) begin
         if (is_alnum(prev) && is_alnum(nx)) begin
            s.b2 = TAIL_RSQ;
         end else begin
            s.b2 = sq ? TAIL_LSQ : TAIL_RSQ;
            s.sq = ~sq;
         end
      end else if (c == CHAR_DQUOT) begin
         s.b2 = (is_space(prev) || is_punct(prev)) ? TAIL_LDQ : TAIL_RDQ;
      end else begin
         s.len3 = 1'b0;
         s.b0   = c;
      end
      return s;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/styp_decide.sv =====
// Lookahead window, quote and index state, and glyph decisions for one accepted beat.
`timescale 1ns / 1ps
`default_nettype none
module styp_decide #(
   parameter int INDEX_BITS = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire styp_pkg::req_type   req_in,
   output styp_pkg::batch_type      batch
);
   import styp_pkg::*;

   logic [7:0]            win0_ff, win1_ff, win0_in, win1_in;
   logic [1:0]            wc_ff, wc_in;
   logic [7:0]            prev_ff, prev_in;
   logic [1:0]            skip_ff, skip_in;
   logic                  sq_ff, sq_in;
   logic [INDEX_BITS-1:0] idx_ff, idx_in;

   logic [7:0]            bufb [5];
   logic [1:0]            n;
   logic                  act;
   logic                  h1, h2;
   logic [1:0]            skip;
   logic [7:0]            prev;
   logic                  sq;
   logic [INDEX_BITS-1:0] idx;
   step_type              st;

   function automatic logic [15:0] sat16(input logic [INDEX_BITS-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return (|w[31:16]) ? 16'hFFFF : w[15:0];
   endfunction

   always_comb begin
      bufb[3] = '0;
      bufb[4] = '0;
      case (wc_ff)
         2'd0: begin
            bufb[0] = req_in.data_byte;
            bufb[1] = '0;
            bufb[2] = '0;
            n       = 2'd1;
         end
         2'd1: begin
            bufb[0] = win0_ff;
            bufb[1] = req_in.data_byte;
            bufb[2] = '0;
            n       = 2'd2;
         end
         default: begin
            bufb[0] = win0_ff;
            bufb[1] = win1_ff;
            bufb[2] = req_in.data_byte;
            n       = 2'd3;
         end
      endcase

      skip  = skip_ff;
      prev  = prev_ff;
      sq    = sq_ff;
      idx   = idx_ff;
      batch = '0;
      batch.last = req_in.last_byte;
      st    = '0;
      h1    = 1'b0;
      h2    = 1'b0;
      act   = 1'b0;
      for (int p = 0; p < 3; p++) begin
         act = req_in.last_byte ? (3'(p) < {1'b0, n}) : (p == 0 && n == 2'd3);
         h1  = 3'(p + 1) < {1'b0, n};
         h2  = 3'(p + 2) < {1'b0, n};
         if (act) begin
            if (skip != 2'd0) begin
               skip = skip - 2'd1;
            end else begin
               st = decide_step(bufb[p], bufb[p+1], h1, bufb[p+2], h2, prev, sq);
               batch.mask[p]        = 1'b1;
               batch.glyphs[p].len3 = st.len3;
               batch.glyphs[p].b0   = st.b0;
               batch.glyphs[p].b2   = st.b2;
               batch.glyphs[p].src  = sat16(idx);
               skip = st.used - 2'd1;
               sq   = st.sq;
            end
            prev = bufb[p];
            if (idx != '1) begin
               idx = idx + INDEX_BITS'(1);
            end
         end
      end

      if (req_in.last_byte) begin
         win0_in = '0;
         win1_in = '0;
         wc_in   = 2'd0;
         prev_in = CHAR_SPACE;
         skip_in = 2'd0;
         sq_in   = 1'b1;
         idx_in  = '0;
      end else begin
         if (n == 2'd3) begin
            win0_in = bufb[1];
            win1_in = bufb[2];
            wc_in   = 2'd2;
         end else begin
            win0_in = bufb[0];
            win1_in = bufb[1];
            wc_in   = n;
         end
         prev_in = prev;
         skip_in = skip;
         sq_in   = sq;
         idx_in  = idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win0_ff <= '0;
         win1_ff <= '0;
         wc_ff   <= 2'd0;
         prev_ff <= CHAR_SPACE;
         skip_ff <= 2'd0;
         sq_ff   <= 1'b1;
         idx_ff  <= '0;
      end else if (accept) begin
         win0_ff <= win0_in;
         win1_ff <= win1_in;
         wc_ff   <= wc_in;
         prev_ff <= prev_in;
         skip_ff <= skip_in;
         sq_ff   <= sq_in;
         idx_ff  <= idx_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/styp_emit.sv =====
// Result register and serialiser: holds up to three glyphs and sends one byte per beat.
`timescale 1ns / 1ps
`default_nettype none
module styp_emit (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  load,
   input  wire styp_pkg::batch_type   batch_new,
   output logic                       free,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output styp_pkg::rsp_type          rsp_data
);
   import styp_pkg::*;

   batch_type  batch_ff, batch_in;
   logic [1:0] bp_ff, bp_in;
   logic [1:0] cur;
   glyph_type  g;
   logic       glyph_done;
   logic       more;
   logic       beat_last;
   logic       fire;

   always_comb begin
      if (batch_ff.mask[0]) begin
         cur = 2'd0;
      end else if (batch_ff.mask[1]) begin
         cur = 2'd1;
      end else begin
         cur = 2'd2;
      end
      g = batch_ff.glyphs[cur];
      case (cur)
         2'd0:    more = |batch_ff.mask[2:1];
         2'd1:    more = batch_ff.mask[2];
         default: more = 1'b0;
      endcase
      glyph_done = !g.len3 || bp_ff == 2'd2;
      beat_last  = glyph_done && !more;
      rsp_valid  = |batch_ff.mask;
      fire       = rsp_valid && rsp_ready;
      free       = !rsp_valid || (rsp_ready && beat_last);

      if (!g.len3) begin
         rsp_data.out_byte = g.b0;
      end else begin
         case (bp_ff)
            2'd0:    rsp_data.out_byte = BYTE_LEAD;
            2'd1:    rsp_data.out_byte = BYTE_MID;
            default: rsp_data.out_byte = g.b2;
         endcase
      end
      rsp_data.glyph_start  = bp_ff == 2'd0;
      rsp_data.source_index = (bp_ff == 2'd0) ? g.src : 16'd0;
      rsp_data.run_end      = beat_last;
      rsp_data.string_end   = beat_last && batch_ff.last;

      batch_in = batch_ff;
      bp_in    = bp_ff;
      if (load) begin
         batch_in = batch_new;
         bp_in    = 2'd0;
      end else if (fire) begin
         if (glyph_done) begin
            batch_in.mask[cur] = 1'b0;
            bp_in              = 2'd0;
         end else begin
            bp_in = bp_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_ff <= '0;
         bp_ff    <= 2'd0;
      end else begin
         batch_ff <= batch_in;
         bp_ff    <= bp_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/smart_typography_rewriter_unit.sv =====
// Top level of the smart typography rewriter.
// Streams a string byte by byte and rewrites dashes, ellipses and quotes into UTF-8
// glyphs, holding two bytes of lookahead. Results leave one byte per cycle on the rsp
// port while rsp_ready is high, so an input beat that completes a typographic glyph
// yields three bytes, a plain byte one, a beat still filling the window none, and a
// final beat that flushes the window up to nine. A new beat is taken in the cycle the
// last byte of the previous one is taken. The position count saturates at the index
// width, and source_index shows it clipped to 16 bits.
`timescale 1ns / 1ps
`default_nettype none
module smart_typography_rewriter_unit #(
   parameter int INDEX_BITS = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire styp_pkg::req_type   req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output styp_pkg::rsp_type        rsp_data
);
   import styp_pkg::*;

   batch_type batch;
   logic      accept;
   logic      free;

   assign req_ready = free;
   assign accept    = req_valid && free;

   styp_decide #(
      .INDEX_BITS(INDEX_BITS)
   ) u_decide (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req_in (req_data),
      .batch  (batch)
   );

   styp_emit u_emit (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .batch_new (batch),
      .free      (free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the smart typography rewriter: directed table and random strings.
`timescale 1ns / 1ps
module testbench;
   import styp_pkg::*;

   localparam int              POS_BITS     = 16;
   localparam longint unsigned POS_MAX      = (64'd1 << POS_BITS) - 64'd1;
   localparam int              RANDOM_BEATS = 175;
   localparam int              IDLE_LIMIT   = 2000;
   localparam int              SETTLE       = 20;

   typedef enum logic [1:0] {ROW_PREDICT, ROW_QUIET, ROW_GLYPH} row_kind_type;

   // kind says whether the expected glyph is typed in the row, absent, or left to the predictor
   typedef struct packed {
      logic [7:0]   data;
      logic         last;
      row_kind_type kind;
      logic         wide;
      logic [7:0]   code;
      logic [15:0]  src;
   } stim_row_type;

   localparam int N_DIRECTED = 25;
   localparam stim_row_type DIRECTED [N_DIRECTED] = '{
      '{8'h41,      1'b1, ROW_GLYPH,   1'b0, 8'h41,    16'd0},
      '{CHAR_DASH,  1'b0, ROW_QUIET,   1'b0, 8'h00,    16'd0},
      '{CHAR_DASH,  1'b0, ROW_QUIET,   1'b0, 8'h00,    16'd0},
      '{CHAR_DASH,  1'b1, ROW_GLYPH,   1'b1, TAIL_EM,  16'd0},
      '{CHAR_DASH,  1'b0, ROW_QUIET,   1'b0, 8'h00,    16'd0},
      '{CHAR_DASH,  1'b1, ROW_GLYPH,   1'b1, TAIL_EN,  16'd0},
      '{CHAR_DOT,   1'b0, ROW_QUIET,   1'b0, 8'h00,    16'd0},
      '{CHAR_DOT,   1'b0, ROW_QUIET,   1'b0, 8'h00,    16'd0},
      '{CHAR_DOT,   1'b1, ROW_GLYPH,   1'b1, TAIL_ELL, 16'd0},
      '{CHAR_APOS,  1'b1, ROW_GLYPH,   1'b1, TAIL_LSQ, 16'd0},
      '{CHAR_DQUOT, 1'b1, ROW_GLYPH,   1'b1, TAIL_LDQ, 16'd0},
      '{8'h00,      1'b1, ROW_GLYPH,   1'b0, 8'h00,    16'd0},
      '{8'hFF,      1'b1, ROW_GLYPH,   1'b0, 8'hFF,    16'd0},
      '{8'h01,      1'b1, ROW_GLYPH,   1'b0, 8'h01,    16'd0},
      '{8'h61,      1'b0, ROW_QUIET,   1'b0, 8'h00,    16'd0},
      '{CHAR_APOS,  1'b0, ROW_QUIET,   1'b0, 8'h00,    16'd0},
      '{8'h62,      1'b0, ROW_PREDICT, 1'b0, 8'h00,    16'd0},
      '{CHAR_APOS,  1'b1, ROW_PREDICT, 1'b0, 8'h00,    16'd0},
      '{8'h78,      1'b0, ROW_QUIET,   1'b0, 8'h00,    16'd0},
      '{CHAR_DQUOT, 1'b1, ROW_PREDICT, 1'b0, 8'h00,    16'd0},
      '{CHAR_DASH,  1'b0, ROW_QUIET,   1'b0, 8'h00,    16'd0},
      '{CHAR_DASH,  1'b0, ROW_QUIET,   1'b0, 8'h00,    16'd0},
      '{CHAR_DASH,  1'b0, ROW_PREDICT, 1'b0, 8'h00,    16'd0},
      '{CHAR_DASH,  1'b0, ROW_PREDICT, 1'b0, 8'h00,    16'd0},
      '{CHAR_DOT,   1'b1, ROW_PREDICT, 1'b0, 8'h00,    16'd0}
   };

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_type      req_data  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_type      rsp_data;
   stim_row_type beat_note = '0;

   // rewriter state as the predictor sees it
   logic [7:0]      window_bytes [2];
   int              window_fill;
   logic [7:0]      prior_raw;
   int              bytes_to_skip;
   bit              apos_opens;
   longint unsigned next_pos;

   rsp_type fresh_bytes [$];
   rsp_type bytes_due [$];
   int      mismatches  = 0;
   int      idle_cycles = 0;
   int      burst_left  = 0;
   int      ready_left  = 0;

   always #5 clock = ~clock;

   smart_typography_rewriter_unit #(
      .INDEX_BITS(POS_BITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   function automatic bit is_word_char(input logic [7:0] b);
      return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
             (b >= 8'h61 && b <= 8'h7A);
   endfunction

   function automatic bit is_blank(input logic [7:0] b);
      return b == CHAR_SPACE || (b >= 8'h09 && b <= 8'h0D);
   endfunction

   function automatic bit is_mark(input logic [7:0] b);
      return (b >= 8'h21 && b <= 8'h2F) || (b >= 8'h3A && b <= 8'h40) ||
             (b >= 8'h5B && b <= 8'h60) || (b >= 8'h7B && b <= 8'h7E);
   endfunction

   function automatic void clear_predictor();
      window_bytes[0] = 8'h00;
      window_bytes[1] = 8'h00;
      window_fill     = 0;
      prior_raw       = CHAR_SPACE;
      bytes_to_skip   = 0;
      apos_opens      = 1'b1;
      next_pos        = 0;
   endfunction

   function automatic void emit_glyph(input logic wide, input logic [7:0] code,
                                      input longint unsigned at);
      rsp_type r;
      r              = '0;
      r.out_byte     = wide ? BYTE_LEAD : code;
      r.glyph_start  = 1'b1;
      r.source_index = (at > 64'hFFFF) ? 16'hFFFF : at[15:0];
      fresh_bytes.push_back(r);
      if (wide) begin
         r          = '0;
         r.out_byte = BYTE_MID;
         fresh_bytes.push_back(r);
         r.out_byte = code;
         fresh_bytes.push_back(r);
      end
   endfunction

   function automatic void close_run(input logic fin);
      rsp_type tail_byte;
      if (fresh_bytes.size() != 0) begin
         tail_byte            = fresh_bytes.pop_back();
         tail_byte.run_end    = 1'b1;
         tail_byte.string_end = fin;
         fresh_bytes.push_back(tail_byte);
      end
   endfunction

   // bytes are decided once two more have arrived, or all at once on the last beat
   function automatic void rewrite_beat(input req_type beat);
      logic [7:0] held [3];
      logic [7:0] c;
      logic [7:0] n1;
      logic [7:0] n2;
      logic [7:0] code;
      bit         h1;
      bit         h2;
      bit         wide;
      int         n;
      int         p;
      int         k;
      int         used;
      fresh_bytes.delete();
      n = 0;
      for (k = 0; k < window_fill; k++) begin
         held[n] = window_bytes[k];
         n++;
      end
      held[n] = beat.data_byte;
      n++;
      p = 0;
      while (p < n && (beat.last_byte || n - p == 3)) begin
         if (bytes_to_skip > 0) begin
            bytes_to_skip--;
         end else begin
            h1   = p + 1 < n;
            h2   = p + 2 < n;
            c    = held[p];
            n1   = h1 ? held[p + 1] : 8'h00;
            n2   = h2 ? held[p + 2] : 8'h00;
            wide = 1'b1;
            used = 1;
            code = 8'h00;
            if (c == CHAR_DASH && h1 && n1 == CHAR_DASH && h2 && n2 == CHAR_DASH) begin
               code = TAIL_EM;
               used = 3;
            end else if (c == CHAR_DASH && h1 && n1 == CHAR_DASH) begin
               code = TAIL_EN;
               used = 2;
            end else if (c == CHAR_DOT && h1 && n1 == CHAR_DOT && h2 && n2 == CHAR_DOT) begin
               code = TAIL_ELL;
               used = 3;
            end else if (c == CHAR_APOS) begin
               if (is_word_char(prior_raw) && is_word_char(h1 ? n1 : CHAR_SPACE)) begin
                  code = TAIL_RSQ;
               end else begin
                  code       = apos_opens ? TAIL_LSQ : TAIL_RSQ;
                  apos_opens = !apos_opens;
               end
            end else if (c == CHAR_DQUOT) begin
               code = (is_blank(prior_raw) || is_mark(prior_raw)) ? TAIL_LDQ : TAIL_RDQ;
            end else begin
               wide = 1'b0;
               code = c;
            end
            emit_glyph(wide, code, next_pos);
            bytes_to_skip = used - 1;
         end
         prior_raw = held[p];
         if (next_pos < POS_MAX) begin
            next_pos++;
         end
         p++;
      end
      window_fill = n - p;
      for (k = 0; k < window_fill; k++) begin
         window_bytes[k] = held[p + k];
      end
      close_run(beat.last_byte);
      if (beat.last_byte) begin
         clear_predictor();
      end
   endfunction

   function automatic void flag(input string what, input rsp_type want, input rsp_type got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%s: want %h/%b/%0d/%b/%b got %h/%b/%0d/%b/%b", what,
                  want.out_byte, want.glyph_start, want.source_index, want.run_end,
                  want.string_end, got.out_byte, got.glyph_start, got.source_index,
                  got.run_end, got.string_end);
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            rewrite_beat(req_data);
            if (beat_note.kind != ROW_PREDICT) begin
               fresh_bytes.delete();
               if (beat_note.kind == ROW_GLYPH) begin
                  emit_glyph(beat_note.wide, beat_note.code, beat_note.src);
               end
               close_run(req_data.last_byte);
            end
            foreach (fresh_bytes[i]) begin
               bytes_due.push_back(fresh_bytes[i]);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (bytes_due.size() == 0) begin
               flag("result with nothing due", '0, rsp_data);
            end else begin
               want = bytes_due.pop_front();
               if (rsp_data.out_byte !== want.out_byte ||
                   rsp_data.glyph_start !== want.glyph_start ||
                   rsp_data.source_index !== want.source_index ||
                   rsp_data.run_end !== want.run_end ||
                   rsp_data.string_end !== want.string_end) begin
                  flag("result mismatch", want, rsp_data);
               end
            end
         end
      end
   end

   // receiver: short stalls between ready runs, now and then a long free stretch
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         ready_left <= 0;
      end else if (ready_left == 0) begin
         rsp_ready <= ~rsp_ready;
         if (rsp_ready) begin
            ready_left <= $urandom_range(0, 3);
         end else begin
            ready_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) :
                                                         $urandom_range(0, 5);
         end
      end else begin
         ready_left <= ready_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [7:0] pick_byte();
      logic [7:0] pick;
      case ($urandom_range(0, 15))
         0, 1, 2, 3: pick = CHAR_DASH;
         4, 5:       pick = CHAR_DOT;
         6:          pick = CHAR_APOS;
         7:          pick = CHAR_DQUOT;
         8:          pick = $urandom_range(0, 1) ? CHAR_SPACE : 8'($urandom_range(9, 13));
         9, 10, 11: begin
            case ($urandom_range(0, 2))
               0:       pick = 8'($urandom_range(8'h30, 8'h39));
               1:       pick = 8'($urandom_range(8'h41, 8'h5A));
               default: pick = 8'($urandom_range(8'h61, 8'h7A));
            endcase
         end
         12:         pick = 8'($urandom_range(8'h21, 8'h2F));
         default:    pick = 8'($urandom_range(0, 255));
      endcase
      return pick;
   endfunction

   function automatic stim_row_type random_row(input logic fin);
      stim_row_type row;
      row      = '0;
      row.data = pick_byte();
      row.last = fin;
      row.kind = ROW_PREDICT;
      return row;
   endfunction

   task automatic send_row(input stim_row_type row);
      req_valid <= 1'b1;
      req_data  <= '{data_byte: row.data, last_byte: row.last};
      beat_note <= row;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 15);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (bytes_due.size() != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      int sent;
      int len;
      clear_predictor();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (DIRECTED[i]) begin
         send_row(DIRECTED[i]);
      end
      wait_drained();
      sent = 0;
      while (sent < RANDOM_BEATS) begin
         len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 14);
         for (int i = 0; i < len; i++) begin
            send_row(random_row(i == len - 1));
         end
         sent += len;
         if ($urandom_range(0, 7) == 0) begin
            wait_drained();
         end
      end
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0 && bytes_due.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
